/* rtl/tspf_pkg.sv */
// tspf_pkg: constants, request and status codes shared by the PID filter design.
// No dependencies.
`timescale 1ns / 1ps
package tspf_pkg;
	localparam int SECTION_DEPTH_DEF = 4096;
	localparam int PKT_BYTES         = 188;
	localparam int PTR_MAX           = PKT_BYTES - 5;
	localparam int PAYLOAD_BYTES     = PKT_BYTES - 4;
	localparam logic [12:0] FILL_MAX = 13'd8191;
	localparam logic [7:0]  SYNC_BYTE = 8'h47;
	localparam logic [12:0] CAP_RESET = 13'd4096;

	// request codes
	localparam logic [1:0] REQ_BYTE  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// result kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// packet verdicts
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_SYNC = 3'd1;
	localparam logic [2:0] ST_ERR_BIT  = 3'd2;
	localparam logic [2:0] ST_PID_MISS = 3'd3;
	localparam logic [2:0] ST_OVER_CAP = 3'd4;

	// register indexes
	localparam logic REG_PID = 1'b0;
	localparam logic REG_CAP = 1'b1;

	// store port strobes
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} tspf_mem_ctl_t;
endpackage

/* rtl/tspf_section_store.sv */
// tspf_section_store: section byte store, one write and one registered read port.
// Depends on tspf_pkg.
`timescale 1ns / 1ps
module tspf_section_store
	import tspf_pkg::*;
#(
	parameter int SECTION_DEPTH = SECTION_DEPTH_DEF,
	localparam int AW = $clog2(SECTION_DEPTH)
) (
	input  logic          clk,
	input  tspf_mem_ctl_t ctl,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);
	logic [7:0] mem [0:SECTION_DEPTH-1];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

/* rtl/ts_pid_filter_section_assembler_top.sv */
// ts_pid_filter_section_assembler_top: transport stream PID filter and section assembler.
// Depends on tspf_pkg and tspf_section_store.
`timescale 1ns / 1ps
// Usage
//  Input words (in_valid/in_ready) carry one request: a packet byte, a section
//  store read or a fill clear. Packet bytes arrive one per word, packet_start on
//  byte 0. Output words (out_valid/out_ready) carry a packet status after the
//  last byte of a packet, or the data of a store read.
//  A clear, or a packet byte other than header byte 3 of an accepted packet,
//  leaves in_ready high for the next word. After a read, in_ready is low in the
//  read-wait state while the registered store read completes. Header byte 3 of
//  an accepted packet copies the held remainder from the previous start packet
//  into the store, one byte per cycle through the held buffer read port, in the
//  flush state, during which in_ready is low. A status word appears the cycle
//  after the last byte; read data is loaded into the output register in the read-wait state.
//  Results sit in an output register; the next word is taken while the pending
//  result is being taken. If the receiver stalls, in_ready drops until it drains.
//  Reset clears all control state and sets wanted_pid 0, section_capacity 4096.
//  Store and held buffer contents are not cleared; the fill count tracks them.
//  Registers via APB: wanted_pid at 0x0, section_capacity at 0x4.
module ts_pid_filter_section_assembler_top
	import tspf_pkg::*;
#(
	parameter int SECTION_DEPTH = SECTION_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  data_byte,
	input  logic        packet_start,
	input  logic [11:0] read_address,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [2:0]  packet_status,
	output logic [12:0] section_length,
	output logic [7:0]  read_data
);
	localparam int AW = $clog2(SECTION_DEPTH);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_FLUSH  = 2'd1;
	localparam logic [1:0] S_RDWAIT = 2'd2;

	// config registers
	logic [12:0] wanted_pid_q, capacity_q;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_pid_q <= '0;
			capacity_q   <= CAP_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_PID) wanted_pid_q <= pwdata[12:0];
			else capacity_q <= pwdata[12:0];
		end
	end
	assign prdata = (paddr[2] == REG_PID) ? {19'd0, wanted_pid_q} : {19'd0, capacity_q};

	// state
	logic [1:0]  st_q, st_d;
	logic [7:0]  bytepos_q, bytepos_d;
	logic [31:0] header_q, header_d;
	logic [7:0]  tail_q, tail_d;
	logic [2:0]  verdict_q, verdict_d;
	logic [7:0]  held_cnt_q, held_cnt_d;
	logic [12:0] fill_q, fill_d;
	logic [7:0]  fl_idx_q, fl_idx_d;
	logic        fl_vld_s1;
	logic        oor_s1;

	// output register
	logic        out_valid_q;
	logic        out_kind_q;
	logic [2:0]  out_status_q;
	logic [12:0] out_len_q;
	logic [7:0]  out_data_q;

	// held buffer
	logic [7:0] held_mem [0:PKT_BYTES-1];
	logic [7:0] held_rdata;
	logic       held_we, held_re;

	// store port
	tspf_mem_ctl_t   mem_ctl;
	logic [7:0]      put_data;
	logic            put_en;
	logic [AW-1:0]   st_wr_addr, st_rd_addr;
	logic [7:0]      st_rd_data;
	logic [AW+12:0]  fill_ext;
	logic [AW+11:0]  addr_ext;

	logic        accept;
	logic [7:0]  pos;
	logic [31:0] hdr_base;
	logic [2:0]  vd_base, v_hdr;
	logic [7:0]  tail_base, ptr;
	logic        start_bit;
	logic [13:0] ptr_sum, cap_sum;
	logic        load_status, load_read, fl_issue, fl_done;

	assign in_ready = (st_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	assign fill_ext   = {{AW{1'b0}}, fill_q};
	assign addr_ext   = {{AW{1'b0}}, read_address};
	assign st_wr_addr = fill_ext[AW-1:0];
	assign st_rd_addr = addr_ext[AW-1:0];

	assign cap_sum  = {1'b0, fill_q} + 14'(PAYLOAD_BYTES);
	assign fl_issue = (st_q == S_FLUSH) && (fl_idx_q < held_cnt_q);
	assign fl_done  = (st_q == S_FLUSH) && (fl_idx_q == held_cnt_q) && !fl_vld_s1;

	always_comb begin
		st_d        = st_q;
		bytepos_d   = bytepos_q;
		header_d    = header_q;
		tail_d      = tail_q;
		verdict_d   = verdict_q;
		held_cnt_d  = held_cnt_q;
		fl_idx_d    = fl_idx_q;
		put_en      = 1'b0;
		put_data    = data_byte;
		held_we     = 1'b0;
		held_re     = fl_issue;
		load_status = 1'b0;
		load_read   = 1'b0;
		pos         = packet_start ? 8'd0 : bytepos_q;
		hdr_base    = (pos == 8'd0) ? 32'd0 : header_q;
		vd_base     = (pos == 8'd0) ? ST_OK : verdict_q;
		tail_base   = (pos == 8'd0) ? 8'd0 : tail_q;
		start_bit   = hdr_base[22];
		ptr         = (data_byte > 8'(PTR_MAX)) ? 8'(PTR_MAX) : data_byte;
		ptr_sum     = {1'b0, fill_q} + {6'd0, ptr};
		v_hdr       = ST_OK;

		if (st_q == S_IDLE && accept) begin
			case (req_type)
				REQ_READ: begin
					load_read = 1'b1;
					st_d      = S_RDWAIT;
				end
				REQ_CLEAR: begin
					// fill cleared in the fill update below
				end
				REQ_BYTE: begin
					if (pos >= 8'(PKT_BYTES)) begin
						bytepos_d = 8'(PKT_BYTES);
					end else begin
						bytepos_d = pos + 8'd1;
						header_d  = hdr_base;
						verdict_d = vd_base;
						tail_d    = tail_base;
						if (pos < 8'd4) begin
							header_d = {hdr_base[23:0], data_byte};
							if (pos == 8'd3) begin
								if (header_d[31:24] != SYNC_BYTE) v_hdr = ST_BAD_SYNC;
								else if (header_d[23]) v_hdr = ST_ERR_BIT;
								else if (header_d[20:8] != wanted_pid_q) v_hdr = ST_PID_MISS;
								else v_hdr = ST_OK;
								verdict_d = v_hdr;
								if (v_hdr == ST_OK) begin
									st_d     = S_FLUSH;
									fl_idx_d = '0;
								end else begin
									held_cnt_d = '0;
								end
							end
						end else if (vd_base == ST_OK || vd_base == ST_OVER_CAP) begin
							if (!start_bit) begin
								put_en = (vd_base == ST_OK);
							end else if (pos == 8'd4) begin
								tail_d = ptr;
								if (ptr_sum > {1'b0, capacity_q}) verdict_d = ST_OVER_CAP;
							end else if ((pos - 8'd5) < tail_base) begin
								put_en = (vd_base == ST_OK);
							end else if (held_cnt_q < 8'(PKT_BYTES)) begin
								held_we    = 1'b1;
								held_cnt_d = held_cnt_q + 8'd1;
							end
						end
						load_status = (pos == 8'(PKT_BYTES - 1));
					end
				end
				default: begin
				end
			endcase
		end

		if (st_q == S_FLUSH) begin
			if (fl_issue) fl_idx_d = fl_idx_q + 8'd1;
			if (fl_vld_s1) begin
				put_en   = 1'b1;
				put_data = held_rdata;
			end
			if (fl_done) begin
				held_cnt_d = '0;
				st_d       = S_IDLE;
				if (!header_q[22] && cap_sum > {1'b0, capacity_q}) verdict_d = ST_OVER_CAP;
			end
		end

		if (st_q == S_RDWAIT) st_d = S_IDLE;
	end

	// fill update, kept apart so clear and put share one path
	always_comb begin
		fill_d = fill_q;
		if (st_q == S_IDLE && accept && req_type == REQ_CLEAR) fill_d = '0;
		else if (put_en && fill_q < FILL_MAX) fill_d = fill_q + 13'd1;
	end

	assign mem_ctl.wr_en = put_en && (32'(fill_q) < 32'(SECTION_DEPTH));
	assign mem_ctl.rd_en = load_read;

	tspf_section_store #(
		.SECTION_DEPTH(SECTION_DEPTH)
	) u_store (
		.clk     (clk),
		.ctl     (mem_ctl),
		.wr_addr (st_wr_addr),
		.wr_data (put_data),
		.rd_addr (st_rd_addr),
		.rd_data (st_rd_data)
	);

	always_ff @(posedge clk) begin
		if (held_we) held_mem[held_cnt_q] <= data_byte;
		if (held_re) held_rdata <= held_mem[fl_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			bytepos_q  <= '0;
			header_q   <= '0;
			tail_q     <= '0;
			verdict_q  <= ST_OK;
			held_cnt_q <= '0;
			fill_q     <= '0;
			fl_idx_q   <= '0;
			fl_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q       <= st_d;
			bytepos_q  <= bytepos_d;
			header_q   <= header_d;
			tail_q     <= tail_d;
			verdict_q  <= verdict_d;
			held_cnt_q <= held_cnt_d;
			fill_q     <= fill_d;
			fl_idx_q   <= fl_idx_d;
			fl_vld_s1  <= fl_issue;
			if (load_status || st_q == S_RDWAIT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_read) begin
			oor_s1 <= !(32'(read_address) < 32'(SECTION_DEPTH));
		end
		if (load_status) begin
			out_kind_q   <= KIND_STATUS;
			out_status_q <= verdict_d;
			out_len_q    <= fill_d;
			out_data_q   <= '0;
		end else if (st_q == S_RDWAIT) begin
			out_kind_q   <= KIND_READ;
			out_status_q <= ST_OK;
			out_len_q    <= fill_q;
			out_data_q   <= oor_s1 ? 8'd0 : st_rd_data;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = out_kind_q;
	assign packet_status  = out_status_q;
	assign section_length = out_len_q;
	assign read_data      = out_data_q;

	// checks
	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_RDWAIT |=> out_valid_q && out_kind_q == KIND_READ)
		else $error("read result missing");
	a_flush_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		fl_vld_s1 |-> st_q == S_FLUSH)
		else $error("held byte outside flush");
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt_q <= 8'(PKT_BYTES) && bytepos_q <= 8'(PKT_BYTES))
		else $error("counter out of range");
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		fl_done |=> held_cnt_q == 8'd0 && st_q == S_IDLE)
		else $error("flush did not empty held buffer");
endmodule
